// ===== rtl/integer_to_radix_digits_macros.svh =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits assertion macros
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// same-cycle implication, disabled during reset
`define I2RD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define I2RD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/i2rd_pkg.sv =====
// ----------------------------------------------------------------------------
// i2rd_pkg
// Constants and digit helpers for the integer to radix digits converter.
// ----------------------------------------------------------------------------
package i2rd_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int RADIX_W         = 6;
    localparam int CHAR_W          = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_LIMIT   = 6'd10;
    localparam logic [CHAR_W-1:0]  ZERO_CHAR     = 7'd48;
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 7'd55;

    typedef logic [RADIX_W-1:0] radix_t;
    typedef logic [CHAR_W-1:0]  char_t;

    // clamp the programmed base into 2..36
    function automatic radix_t eff_radix(input radix_t r);
        radix_t res;
        if (r < RADIX_MIN)
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        else
            res = r;
        return res;
    endfunction

    function automatic char_t digit_to_char(input radix_t d);
        char_t res;
        if (d < DIGIT_LIMIT)
            res = {1'b0, d} + ZERO_CHAR;
        else
            res = {1'b0, d} + LETTER_OFFSET;
        return res;
    endfunction

endpackage

// ===== rtl/i2rd_if.sv =====
// ----------------------------------------------------------------------------
// i2rd_if
// Valid/ready channels of the integer to radix digits converter.
// ----------------------------------------------------------------------------
interface i2rd_in_if #(
    parameter int VALUE_WIDTH = i2rd_pkg::VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface i2rd_out_if;
    logic                valid;
    logic                ready;
    i2rd_pkg::char_t     digit_char;
    logic                last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

interface i2rd_cfg_if;
    logic             valid;
    logic             ready;
    i2rd_pkg::radix_t radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

// ===== rtl/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts an unsigned integer to ASCII digits in a programmable base.
// ----------------------------------------------------------------------------
// Usage:
//   item  : one value per transfer; ready is high only while the block is idle.
//   digit : one ASCII digit per transfer, most significant first; last_digit
//           marks the final digit. A value of zero gives the single digit '0'.
//   cfg   : radix write, always ready; bases below 2 act as 2, above 36 as 36.
// Operation:
//   Each digit is produced by the bit-serial restoring divider (one quotient
//   bit per cycle). Digits are kept on a stack memory and replayed most
//   significant first, each by a registered memory read, then output.
// Reset:
//   rst_n clears the controller to idle and the radix to 10.
// Stall:
//   A held digit keeps valid, digit_char and last_digit stable until taken.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
    parameter int VALUE_WIDTH = i2rd_pkg::VALUE_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    i2rd_in_if.sink          item,
    i2rd_out_if.source       digit,
    i2rd_cfg_if.sink         cfg
);

    localparam int AW = $clog2(VALUE_WIDTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_SHOW  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [AW-1:0]          sp_reg, sp_next;
    logic [AW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    i2rd_pkg::radix_t       rem_reg, rem_next;
    i2rd_pkg::radix_t       base_reg, base_next;
    i2rd_pkg::radix_t       radix_reg;
    i2rd_pkg::char_t        rd_data_reg;
    i2rd_pkg::char_t        stack_mem [VALUE_WIDTH];

    logic [i2rd_pkg::RADIX_W:0]  trial;
    logic                        ge;
    logic [VALUE_WIDTH-1:0]      quo_step;
    i2rd_pkg::radix_t            rem_step;
    logic                        push;
    logic                        item_xfer;

    assign item_xfer = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign digit.valid      = (state_reg == ST_SHOW);
    assign digit.digit_char = rd_data_reg;
    assign digit.last_digit = (sp_reg == '0);

    // one restoring division step
    assign trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign ge       = (trial >= {1'b0, base_reg});
    assign rem_step = ge ? i2rd_pkg::RADIX_W'(trial - {1'b0, base_reg})
                         : i2rd_pkg::RADIX_W'(trial);
    assign quo_step = {quo_reg[VALUE_WIDTH-2:0], ge};
    assign push     = (state_reg == ST_DIV) && (bit_cnt_reg == '0);

    always_comb
    begin
        state_next   = state_reg;
        sp_next      = sp_reg;
        bit_cnt_next = bit_cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        base_next    = base_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    quo_next     = item.value;
                    rem_next     = '0;
                    bit_cnt_next = AW'(VALUE_WIDTH - 1);
                    sp_next      = '0;
                    base_next    = i2rd_pkg::eff_radix(radix_reg);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                if (bit_cnt_reg == '0)
                begin
                    if (quo_step == '0)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        sp_next      = sp_reg + 1'b1;
                        rem_next     = '0;
                        bit_cnt_next = AW'(VALUE_WIDTH - 1);
                    end
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (digit.ready)
                begin
                    if (sp_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sp_next    = sp_reg - 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sp_reg      <= '0;
            bit_cnt_reg <= '0;
            radix_reg   <= i2rd_pkg::RADIX_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            bit_cnt_reg <= bit_cnt_next;
            if (cfg.valid && cfg.ready)
            begin
                radix_reg <= cfg.radix;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
    end

    // digit stack: push during division, pop during replay
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[sp_reg] <= i2rd_pkg::digit_to_char(rem_step);
        end
        if (state_reg == ST_FETCH)
        begin
            rd_data_reg <= stack_mem[sp_reg];
        end
    end

endmodule

// ===== rtl/i2rd_checker.sv =====
// ----------------------------------------------------------------------------
// i2rd_checker
// Port-level checks for the integer to radix digits converter.
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_macros.svh"

module i2rd_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_ready,
    input logic                   digit_valid,
    input logic                   digit_ready,
    input i2rd_pkg::char_t        digit_char,
    input logic                   last_digit
);

    logic busy_reg;
    logic busy_next;
    logic item_xfer;
    logic last_xfer;

    assign item_xfer = item_valid && item_ready;
    assign last_xfer = digit_valid && digit_ready && last_digit;

    always_comb
    begin
        busy_next = busy_reg;
        if (item_xfer)
            busy_next = 1'b1;
        else if (last_xfer)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    `I2RD_ASSERT_NEXT(a_stall_hold, clk, rst_n, digit_valid && !digit_ready,
        digit_valid && $stable(digit_char) && $stable(last_digit),
        "stalled digit changed")

    `I2RD_ASSERT_IMPL(a_one_item, clk, rst_n, item_xfer, !busy_reg,
        "item taken before previous digits finished")

    `I2RD_ASSERT_IMPL(a_no_orphan, clk, rst_n, digit_valid, busy_reg,
        "digit shown with no item in flight")

    `I2RD_ASSERT_IMPL(a_char_range, clk, rst_n, digit_valid,
        (digit_char >= 7'd48 && digit_char <= 7'd57) ||
        (digit_char >= 7'd65 && digit_char <= 7'd90),
        "digit character out of range")

endmodule

bind integer_to_radix_digits i2rd_checker u_i2rd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .digit_valid (digit.valid),
    .digit_ready (digit.ready),
    .digit_char  (digit.digit_char),
    .last_digit  (digit.last_digit)
);
